// ----- hw/rtl/hll_pkg.sv -----
// hll_pkg: shared constants, payload structs, opcodes and controller types
// for the hyperloglog counter; no dependencies
package hll_pkg;

    localparam int INDEX_BITS   = 12;
    localparam int HASH_BITS    = 32;
    localparam int REG_COUNT    = 1 << INDEX_BITS;
    localparam int LOW_BITS     = HASH_BITS - INDEX_BITS;
    localparam int RANK_W       = 6;
    localparam int IDX_FIELD_W  = 12;
    localparam int HASH_FIELD_W = 32;
    localparam int EST_W        = 44;
    localparam int ALPHA_W      = 16;
    // q13.32 harmonic sum, wide enough for m * 2^32
    localparam int SUM_W        = INDEX_BITS + 33;
    localparam int DIV_SHIFT    = INDEX_BITS + 16;
    localparam int DIV_STEPS    = 33 + DIV_SHIFT;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 32;

    localparam logic [SUM_W-1:0]      SUM_INIT    = SUM_W'(1) << (INDEX_BITS + 32);
    localparam logic [EST_W-1:0]      EST_MAX     = '1;
    localparam logic [ALPHA_W-1:0]    ALPHA_RESET = 16'd47259;
    localparam logic [RANK_W-1:0]     RANK_MAX    = RANK_W'(HASH_BITS);
    localparam logic [CFG_ADDR_W-1:0] ADDR_ALPHA  = 2'd0;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_MERGE    = 2'd1,
        OP_ESTIMATE = 2'd2,
        OP_CLEAR    = 2'd3
    } op_t;

    typedef struct packed {
        op_t                     op;
        logic [HASH_FIELD_W-1:0] hash_value;
        logic [IDX_FIELD_W-1:0]  merge_index;
        logic [RANK_W-1:0]       merge_rank;
    } in_item_t;

    typedef struct packed {
        logic [IDX_FIELD_W-1:0] reg_index;
        logic [RANK_W-1:0]      reg_value;
        logic [EST_W-1:0]       estimate;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_CLEAR
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic upd;
        logic clr_wr;
        logic div_start;
        logic emit_clear;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic div_done;
    } ctrl_status_t;

endpackage

// ----- hw/rtl/hyperloglog_counter.sv -----
// hyperloglog_counter: top level, apb register file for alpha plus
// controller and datapath; uses hll_pkg, hll_controller, hll_datapath
//
// channel   direction  handshake                    payload
// item      in         start && !busy               hll_pkg::in_item_t
// result    out        done, one cycle, no stall    hll_pkg::out_item_t
// apb       in/out     psel & penable & pwrite      alpha_q16 at byte 0
//
// add and merge: no new item until the update state ends, set by the
//   registered read of the rank ram before the read-modify-write
// estimate: runs the bit-serial divider (61 quotient bits)
// clear: one rank entry zeroed per cycle
// after reset busy stays high while the ram is swept clear
// done and the result are registered after the last work cycle; the
//   receiver cannot stall, so nothing is held back on the output side
module hyperloglog_counter (
    input  logic                             clk,
    input  logic                             rst_n,
    // item channel
    input  logic                             start,
    output logic                             busy,
    input  hll_pkg::in_item_t                item,
    // result channel
    output logic                             done,
    output hll_pkg::out_item_t               result,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hll_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [hll_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [hll_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);

    logic [hll_pkg::ALPHA_W-1:0] alpha_reg, alpha_next;
    logic                        cfg_wr;
    hll_pkg::ctrl_cmd_t          cmd;
    hll_pkg::ctrl_status_t       status;

    // apb: zero wait states, write completes in the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        alpha_next = alpha_reg;
        if (cfg_wr && (paddr == hll_pkg::ADDR_ALPHA))
        begin
            alpha_next = pwdata[hll_pkg::ALPHA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= hll_pkg::ALPHA_RESET;
        end
        else
        begin
            alpha_reg <= alpha_next;
        end
    end

    // unmapped addresses read as zero
    assign prdata = (paddr == hll_pkg::ADDR_ALPHA) ? hll_pkg::CFG_DATA_W'(alpha_reg) : '0;

    // sequencing of ram sweeps, updates and the divider
    hll_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (item.op),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // rank storage, harmonic sum, divider and result register
    hll_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .alpha  (alpha_reg),
        .cmd    (cmd),
        .status (status),
        .result (result),
        .done   (done)
    );

endmodule

// ----- hw/rtl/hll_ram.sv -----
// hll_ram: generic simple dual-port ram, one write and one registered read
// port; no dependencies
module hll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/hll_divider.sv -----
// hll_divider: restoring divider, one quotient bit per cycle, computes
// floor((m * alpha) << (index_bits + 16) / sum) saturated; uses hll_pkg
module hll_divider (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [hll_pkg::ALPHA_W-1:0]       alpha,
    input  logic [hll_pkg::SUM_W-1:0]         divisor,
    output logic                              done,
    output logic [hll_pkg::EST_W-1:0]         quotient
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [hll_pkg::DIV_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [hll_pkg::DIV_STEPS-1:0]     dvd_reg, dvd_next;
    logic [hll_pkg::SUM_W-1:0]         rem_reg, rem_next;
    logic [hll_pkg::EST_W-1:0]         q_reg, q_next;
    logic                              sat_reg, sat_next;
    logic [hll_pkg::SUM_W:0]           rem_shift;
    logic [hll_pkg::SUM_W:0]           rem_sub;
    logic                              ge;

    assign rem_shift = {rem_reg, dvd_reg[hll_pkg::DIV_STEPS-1]};
    assign ge        = rem_shift >= {1'b0, divisor};
    assign rem_sub   = rem_shift - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        sat_next  = sat_reg;
        if (start)
        begin
            // dividend is m * alpha followed by the fixed-point shift
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = hll_pkg::DIV_STEPS'(alpha)
                        << (hll_pkg::INDEX_BITS + hll_pkg::DIV_SHIFT);
            rem_next  = '0;
            q_next    = '0;
            sat_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << 1;
            rem_next = ge ? rem_sub[hll_pkg::SUM_W-1:0] : rem_shift[hll_pkg::SUM_W-1:0];
            q_next   = {q_reg[hll_pkg::EST_W-2:0], ge};
            // a bit leaving the top means the quotient is past the field
            sat_next = sat_reg | q_reg[hll_pkg::EST_W-1];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == hll_pkg::DIV_CNT_W'(hll_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        sat_reg <= sat_next;
    end

    assign done     = done_reg;
    assign quotient = sat_reg ? hll_pkg::EST_MAX : q_reg;

    a_div_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider finished without running");

endmodule

// ----- hw/rtl/hll_datapath.sv -----
// hll_datapath: rank memory, rho and merge-rank logic, harmonic sum,
// clear sweep counter, divider and result register; uses hll_pkg, hll_ram,
// hll_divider
module hll_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hll_pkg::in_item_t             item,
    input  logic [hll_pkg::ALPHA_W-1:0]   alpha,
    input  hll_pkg::ctrl_cmd_t            cmd,
    output hll_pkg::ctrl_status_t         status,
    output hll_pkg::out_item_t            result,
    output logic                          done
);

    logic [hll_pkg::INDEX_BITS-1:0] idx_reg, idx_next;
    logic [hll_pkg::RANK_W-1:0]     rank_reg, rank_next;
    logic [hll_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic [hll_pkg::INDEX_BITS-1:0] clr_cnt_reg, clr_cnt_next;
    hll_pkg::out_item_t             out_reg, out_next;
    logic                           out_valid_reg, out_valid_next;

    logic [hll_pkg::HASH_BITS-1:0]  hash;
    logic [hll_pkg::INDEX_BITS-1:0] in_idx;
    logic [hll_pkg::RANK_W-1:0]     in_rank;
    logic [hll_pkg::RANK_W-1:0]     old_rank;
    logic [hll_pkg::RANK_W-1:0]     new_rank;
    logic                           raise;
    logic                           ram_we;
    logic [hll_pkg::INDEX_BITS-1:0] ram_waddr;
    logic [hll_pkg::RANK_W-1:0]     ram_wdata;
    logic                           div_done;
    logic [hll_pkg::EST_W-1:0]      div_quot;

    // trailing zeros plus one, full hash width when all low bits are zero
    function automatic logic [hll_pkg::RANK_W-1:0] rho_of(
        input logic [hll_pkg::LOW_BITS-1:0] low
    );
        logic [hll_pkg::RANK_W-1:0] r;
        r = hll_pkg::RANK_MAX;
        for (int i = hll_pkg::LOW_BITS - 1; i >= 0; i--)
        begin
            if (low[i])
            begin
                r = hll_pkg::RANK_W'(i + 1);
            end
        end
        return r;
    endfunction

    // 2^-rank in q13.32, raw value 2^(32 - rank)
    function automatic logic [hll_pkg::SUM_W-1:0] weight_of(
        input logic [hll_pkg::RANK_W-1:0] r
    );
        return hll_pkg::SUM_W'(1) << (hll_pkg::RANK_W'(32) - r);
    endfunction

    assign hash = item.hash_value[hll_pkg::HASH_BITS-1:0];

    always_comb
    begin
        if (item.op == hll_pkg::OP_MERGE)
        begin
            in_idx  = hll_pkg::INDEX_BITS'(item.merge_index);
            in_rank = (item.merge_rank > hll_pkg::RANK_MAX) ? hll_pkg::RANK_MAX
                                                            : item.merge_rank;
        end
        else
        begin
            in_idx  = hash[hll_pkg::HASH_BITS-1 -: hll_pkg::INDEX_BITS];
            in_rank = rho_of(hash[hll_pkg::LOW_BITS-1:0]);
        end
    end

    hll_ram #(
        .WIDTH (hll_pkg::RANK_W),
        .DEPTH (hll_pkg::REG_COUNT)
    ) u_rank_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (cmd.capture),
        .rd_addr (in_idx),
        .rd_data (old_rank)
    );

    assign raise     = rank_reg > old_rank;
    assign new_rank  = raise ? rank_reg : old_rank;
    assign ram_we    = cmd.clr_wr | (cmd.upd & raise);
    assign ram_waddr = cmd.clr_wr ? clr_cnt_reg : idx_reg;
    assign ram_wdata = cmd.clr_wr ? '0 : rank_reg;

    hll_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .alpha    (alpha),
        .divisor  (sum_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        idx_next       = cmd.capture ? in_idx : idx_reg;
        rank_next      = cmd.capture ? in_rank : rank_reg;
        clr_cnt_next   = cmd.clr_wr ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
        sum_next       = sum_reg;
        if (cmd.clr_wr)
        begin
            sum_next = hll_pkg::SUM_INIT;
        end
        else if (cmd.upd && raise)
        begin
            sum_next = sum_reg - weight_of(old_rank) + weight_of(rank_reg);
        end
        out_valid_next = cmd.upd | div_done | cmd.emit_clear;
        out_next       = '0;
        if (cmd.upd)
        begin
            out_next.reg_index = hll_pkg::IDX_FIELD_W'(idx_reg);
            out_next.reg_value = new_rank;
        end
        else if (div_done)
        begin
            out_next.estimate = div_quot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= hll_pkg::SUM_INIT;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        rank_reg <= rank_next;
        out_reg  <= out_next;
    end

    assign status.clr_last = &clr_cnt_reg;
    assign status.div_done = div_done;
    assign result          = out_reg;
    assign done            = out_valid_reg;

    a_sum_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (sum_reg <= hll_pkg::SUM_INIT)
        && (sum_reg >= hll_pkg::SUM_W'(hll_pkg::REG_COUNT)))
        else $error("harmonic sum out of range");

endmodule

// ----- hw/rtl/hll_controller.sv -----
// hll_controller: state machine sequencing update, estimate and clear
// sweeps for the hyperloglog counter; uses hll_pkg
module hll_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  hll_pkg::op_t          op,
    input  hll_pkg::ctrl_status_t status,
    output hll_pkg::ctrl_cmd_t    cmd,
    output logic                  busy
);

    hll_pkg::ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hll_pkg::ST_INIT:
            begin
                if (status.clr_last)
                begin
                    state_next = hll_pkg::ST_IDLE;
                end
            end
            hll_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (op) inside
                        hll_pkg::OP_ADD, hll_pkg::OP_MERGE: state_next = hll_pkg::ST_UPDATE;
                        hll_pkg::OP_ESTIMATE:               state_next = hll_pkg::ST_DIVIDE;
                        hll_pkg::OP_CLEAR:                  state_next = hll_pkg::ST_CLEAR;
                        default:                            state_next = hll_pkg::ST_IDLE;
                    endcase
                end
            end
            hll_pkg::ST_UPDATE:
            begin
                state_next = hll_pkg::ST_IDLE;
            end
            hll_pkg::ST_DIVIDE:
            begin
                if (status.div_done)
                begin
                    state_next = hll_pkg::ST_IDLE;
                end
            end
            hll_pkg::ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = hll_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hll_pkg::ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        cmd.capture    = (state_reg == hll_pkg::ST_IDLE) && start;
        cmd.div_start  = cmd.capture && (op == hll_pkg::OP_ESTIMATE);
        cmd.upd        = (state_reg == hll_pkg::ST_UPDATE);
        cmd.clr_wr     = (state_reg == hll_pkg::ST_INIT) || (state_reg == hll_pkg::ST_CLEAR);
        cmd.emit_clear = (state_reg == hll_pkg::ST_CLEAR) && status.clr_last;
        busy           = (state_reg != hll_pkg::ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hll_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_upd_after_capture: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd |-> $past(cmd.capture))
        else $error("update without a captured item");

    a_div_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> (state_reg == hll_pkg::ST_DIVIDE))
        else $error("divider finished outside the estimate state");

endmodule

// ----- tb/hll_checker.sv -----
// hll_checker: watches the item, result and apb channels of the hyperloglog
// counter, keeps its own copy of the rank registers and harmonic sum, and
// compares every result transfer field by field; depends on hll_pkg only
`timescale 1ns / 100ps

module hll_checker
    import hll_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  in_item_t              item,
    input  logic                  done,
    input  out_item_t             result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    input  logic [CFG_DATA_W-1:0] prdata,
    input  logic                  pready,
    output int                    pending,
    output int                    mismatches
);

    logic [RANK_W-1:0]  rank_copy [REG_COUNT];
    logic [63:0]        harmonic_sum_q32;
    logic [ALPHA_W-1:0] alpha_copy;
    out_item_t          expected_results [$];
    int                 backlog = 0;
    int                 mismatch_count = 0;

    assign pending    = backlog;
    assign mismatches = mismatch_count;

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (mismatch_count < 100)
            $display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // q32.32 weight of one register, 2^-rank
    function automatic logic [63:0] rank_weight(input logic [RANK_W-1:0] rank);
        return 64'd1 << (32 - int'(rank));
    endfunction

    task automatic empty_counter();
        for (int k = 0; k < REG_COUNT; k++)
            rank_copy[k] = '0;
        harmonic_sum_q32 = 64'(REG_COUNT) << 32;
    endtask

    task automatic raise_rank(input logic [INDEX_BITS-1:0] slot,
                              input logic [RANK_W-1:0] rank, output out_item_t res);
        logic [RANK_W-1:0] held;
        begin
            held = rank_copy[slot];
            if (rank > held)
            begin
                harmonic_sum_q32 = harmonic_sum_q32 - rank_weight(held) + rank_weight(rank);
                rank_copy[slot]  = rank;
                held             = rank;
            end
            res           = '0;
            res.reg_index = IDX_FIELD_W'(slot);
            res.reg_value = held;
        end
    endtask

    task automatic predict_result(input in_item_t it, output out_item_t res);
        logic [HASH_BITS-1:0] hash;
        logic [LOW_BITS-1:0]  tail;
        logic [RANK_W-1:0]    rho;
        logic [RANK_W-1:0]    rank;
        logic [63:0]          numer;
        logic [63:0]          quot;
        begin
            res = '0;
            case (it.op)
                OP_ADD:
                begin
                    hash = it.hash_value[HASH_BITS-1:0];
                    tail = hash[LOW_BITS-1:0];
                    // all-zero tail counts as the full hash width
                    rho  = RANK_MAX;
                    if (tail != '0)
                    begin
                        rho = RANK_W'(1);
                        while (!tail[0])
                        begin
                            tail = tail >> 1;
                            rho  = rho + 1'b1;
                        end
                    end
                    raise_rank(hash[HASH_BITS-1 -: INDEX_BITS], rho, res);
                end
                OP_MERGE:
                begin
                    rank = (it.merge_rank > RANK_MAX) ? RANK_MAX : it.merge_rank;
                    raise_rank(it.merge_index[INDEX_BITS-1:0], rank, res);
                end
                OP_ESTIMATE:
                begin
                    numer = (64'(REG_COUNT) * 64'(alpha_copy)) << DIV_SHIFT;
                    quot  = numer / harmonic_sum_q32;
                    res.estimate = (quot > 64'(EST_MAX)) ? EST_MAX : quot[EST_W-1:0];
                end
                default:
                    empty_counter();
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        out_item_t want;
        if (!rst_n)
        begin
            empty_counter();
            alpha_copy = ALPHA_RESET;
            expected_results.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                    note_mismatch("result with nothing pending", 64'(result), 64'd0);
                else
                begin
                    want = expected_results.pop_front();
                    if (result.reg_index !== want.reg_index)
                        note_mismatch("reg_index", 64'(result.reg_index), 64'(want.reg_index));
                    if (result.reg_value !== want.reg_value)
                        note_mismatch("reg_value", 64'(result.reg_value), 64'(want.reg_value));
                    if (result.estimate !== want.estimate)
                        note_mismatch("estimate", 64'(result.estimate), 64'(want.estimate));
                end
            end
            if (start && !busy)
            begin
                predict_result(item, want);
                expected_results.push_back(want);
            end
            if (psel && penable && pready && paddr == ADDR_ALPHA)
            begin
                if (pwrite)
                    alpha_copy = pwdata[ALPHA_W-1:0];
                else if (prdata !== CFG_DATA_W'(alpha_copy))
                    note_mismatch("alpha readback", 64'(prdata), 64'(alpha_copy));
            end
        end
        backlog = expected_results.size();
    end

endmodule

// ----- tb/hyperloglog_counter_test.sv -----
// hyperloglog_counter_test: drives items and apb accesses into the counter
// and gives the verdict; depends on hll_pkg, hyperloglog_counter, hll_checker
`timescale 1ns / 100ps

module hyperloglog_counter_test;

    import hll_pkg::*;

    // clock and reset, everything driven to a known value from time zero
    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    in_item_t              item_word = '0;
    logic                  done;
    out_item_t             result;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [CFG_DATA_W-1:0] pwdata    = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // status handed back by the checker
    int                    pending_count;
    int                    mismatch_total;

    // clears cost a full ram sweep each, so the random part only gets a few
    int                    clears_left = 10;

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    hyperloglog_counter i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item_word),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    hll_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item_word),
        .done       (done),
        .result     (result),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .pending    (pending_count),
        .mismatches (mismatch_total)
    );

    // all driving happens at the falling edge; the caller is always sitting
    // on a falling edge when one of these tasks starts

    // hold start high until the transfer goes through; busy only moves at the
    // rising edge, so its value now is what the next rising edge will see
    task automatic send_item(input in_item_t it);
        logic taken;
        begin
            start     <= 1'b1;
            item_word <= it;
            taken = 1'b0;
            while (!taken)
            begin
                taken = !busy;
                @(negedge clk);
            end
        end
    endtask

    // gap in the sender
    task automatic idle_for(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    // stop sending and wait until every expected result transfer has arrived
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending_count != 0) @(negedge clk);
    endtask

    // one apb access: setup cycle, access cycle, then a cycle with psel low
    task automatic apb_access(input logic wr, input logic [CFG_ADDR_W-1:0] addr,
                              input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        while (!pready) @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    function automatic in_item_t make_item(input op_t op, input logic [31:0] hash,
                                           input logic [11:0] slot,
                                           input logic [5:0] rank);
        in_item_t it;
        it.op          = op;
        it.hash_value  = hash;
        it.merge_index = slot;
        it.merge_rank  = rank;
        return it;
    endfunction

    // register index from a narrow pool half the time, so that the same
    // registers get hit over and over and the max logic really works
    function automatic logic [INDEX_BITS-1:0] pick_slot();
        if ($urandom_range(0, 1) != 0)
            return INDEX_BITS'($urandom);
        if ($urandom_range(0, 1) != 0)
            return INDEX_BITS'($urandom_range(0, 31));
        return INDEX_BITS'($urandom_range(REG_COUNT - 32, REG_COUNT - 1));
    endfunction

    // mostly adds and merges, estimates now and then, clears rarely;
    // fields an op does not use carry random noise
    function automatic in_item_t random_item();
        in_item_t it;
        int       pick;
        begin
            it.hash_value  = $urandom;
            it.merge_index = IDX_FIELD_W'($urandom);
            it.merge_rank  = RANK_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 66)
            begin
                it.op = OP_ADD;
                case ($urandom_range(0, 7))
                    0:       it.hash_value[LOW_BITS-1:0] = '0;
                    1, 2:    it.hash_value[LOW_BITS-1:0] =
                                 LOW_BITS'(1) << $urandom_range(0, LOW_BITS - 1);
                    default: ;
                endcase
                it.hash_value[HASH_BITS-1 -: INDEX_BITS] = pick_slot();
            end
            else if (pick < 90)
            begin
                it.op = OP_MERGE;
                it.merge_index = IDX_FIELD_W'(pick_slot());
                // ranks past the hash width now and then, to hit saturation
                if ($urandom_range(0, 3) != 0)
                    it.merge_rank = RANK_W'($urandom_range(0, HASH_BITS));
            end
            else if (pick < 99 || clears_left == 0)
                it.op = OP_ESTIMATE;
            else
            begin
                it.op = OP_CLEAR;
                clears_left--;
            end
            return it;
        end
    endfunction

    initial
    begin : stimulus
        in_item_t           directed [$];
        logic [ALPHA_W-1:0] phase_alpha [4];
        int                 burst_left;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // alpha readback straight out of reset
        apb_access(1'b0, ADDR_ALPHA, '0);

        // directed part with the reset alpha
        directed.push_back(make_item(OP_ESTIMATE, 32'h0, 12'h0, 6'd0));   // empty counter
        directed.push_back(make_item(OP_ADD, 32'h0000_0000, 12'h0, 6'd0)); // zero tail
        directed.push_back(make_item(OP_ADD, 32'hFFFF_FFFF, 12'h0, 6'd0)); // top slot, rho 1
        directed.push_back(make_item(OP_ADD, 32'hFFF0_0000, 12'h0, 6'd0)); // top slot, zero tail
        directed.push_back(make_item(OP_ADD, 32'h0008_0000, 12'h0, 6'd0)); // lower rank, kept
        directed.push_back(make_item(OP_ADD, 32'h1238_0000, 12'h0, 6'd0)); // highest tail bit
        directed.push_back(make_item(OP_ADD, 32'h1230_0001, 12'h0, 6'd0)); // smaller, no change
        directed.push_back(make_item(OP_ADD, 32'h5550_0400, 12'h0, 6'd0));
        directed.push_back(make_item(OP_MERGE, 32'h0, 12'd5, 6'd0));      // rank zero
        directed.push_back(make_item(OP_MERGE, 32'h0, 12'd5, 6'd63));     // saturates to width
        directed.push_back(make_item(OP_MERGE, 32'h0, 12'd6, 6'd33));     // just past width
        directed.push_back(make_item(OP_MERGE, 32'h0, 12'hFFF, 6'd32));   // already there
        directed.push_back(make_item(OP_MERGE, 32'h0, 12'd7, 6'd1));
        directed.push_back(make_item(OP_MERGE, 32'hFFFF_FFFF, 12'hAAA, 6'd21));
        directed.push_back(make_item(OP_ESTIMATE, 32'hFFFF_FFFF, 12'hFFF, 6'd63));
        directed.push_back(make_item(OP_CLEAR, 32'hFFFF_FFFF, 12'hFFF, 6'd63));
        directed.push_back(make_item(OP_ESTIMATE, 32'h0, 12'h0, 6'd0));   // back to empty
        directed.push_back(make_item(OP_MERGE, 32'h0, 12'hFFF, 6'd5));
        directed.push_back(make_item(OP_ADD, 32'hFFF0_0002, 12'h0, 6'd0)); // rho 2, keeps 5
        directed.push_back(make_item(OP_ESTIMATE, 32'h0, 12'h0, 6'd0));
        foreach (directed[k])
            send_item(directed[k]);

        // random phases, one alpha each; the extremes come first
        phase_alpha[0] = '1;
        phase_alpha[1] = '0;
        phase_alpha[2] = ALPHA_W'($urandom);
        phase_alpha[3] = ALPHA_W'($urandom);
        burst_left = 0;
        for (int phase = 0; phase < 4; phase++)
        begin
            // alpha only changes while the counter is idle
            drain();
            apb_access(1'b1, ADDR_ALPHA, CFG_DATA_W'(phase_alpha[phase]));
            apb_access(1'b0, ADDR_ALPHA, '0);
            send_item(make_item(OP_ESTIMATE, $urandom, 12'h0, 6'd0));
            for (int n = 0; n < 345; n++)
            begin
                // sender pauses mid-stream until everything has come back
                if (phase == 1 && n == 150)
                    drain();
                // bursts of random length; a quarter of them follow with no gap
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    if ($urandom_range(0, 3) != 0)
                        idle_for($urandom_range(1, 8));
                end
                send_item(random_item());
                burst_left--;
            end
        end

        // wait out the last results, then a margin past the divider latency
        drain();
        repeat (80) @(negedge clk);

        if (mismatch_total == 0 && pending_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // hard stop, far beyond the slowest clean run
    initial
    begin : watchdog
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- hyperloglog_counter.f -----
hw/rtl/hll_pkg.sv
hw/rtl/hll_ram.sv
hw/rtl/hll_divider.sv
hw/rtl/hll_datapath.sv
hw/rtl/hll_controller.sv
hw/rtl/hyperloglog_counter.sv
tb/hll_checker.sv
tb/hyperloglog_counter_test.sv
